// File: src/sampled_pi_deadband_antiwindup_macros.svh
// Assertion macros for the sampled PI regulator.
// Included by the top level; needs a clock and an active-low reset name.
`ifndef SAMPLED_PI_DEADBAND_ANTIWINDUP_MACROS_SVH
`define SAMPLED_PI_DEADBAND_ANTIWINDUP_MACROS_SVH

// Condition must hold at every edge outside reset.
`define SPDA_ASSERT_ALWAYS(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("spda: invariant violated");

// When the trigger holds, the check must hold in the next cycle.
`define SPDA_ASSERT_NEXT(name, clk, rst_n, trig, check) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (check)) \
        else $error("spda: next-cycle check failed");

`endif

// File: src/spda_pkg.sv
// Shared constants, codes and types for the sampled PI regulator.
// Used by spda_div and sampled_pi_deadband_antiwindup; no dependencies.
`default_nettype none

package spda_pkg;

    localparam int MAX_GENERATORS = 8;
    localparam int LEVEL_HIGH     = 16384;
    localparam int LEVEL_LOW      = -16384;
    localparam int PCT_SCALE      = 100;
    localparam int MASK_W         = 8;
    localparam int FRAC_W         = 14;

    localparam int DIV_NUM_W = 32 + FRAC_W;
    localparam int DIV_DEN_W = 31;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam logic signed [15:0] LVL_HI = 16'(LEVEL_HIGH);
    localparam logic signed [15:0] LVL_LO = 16'(LEVEL_LOW);

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_INIT = 1'b1;

    localparam logic [2:0] CFG_REF     = 3'd0;
    localparam logic [2:0] CFG_DB      = 3'd1;
    localparam logic [2:0] CFG_KI      = 3'd2;
    localparam logic [2:0] CFG_KP      = 3'd3;
    localparam logic [2:0] CFG_PERIOD  = 3'd4;
    localparam logic [2:0] CFG_NGEN    = 3'd5;
    localparam logic [2:0] CFG_QR      = 3'd6;

    localparam logic [1:0] FEV_NONE    = 2'd0;
    localparam logic [1:0] FEV_FROZE   = 2'd1;
    localparam logic [1:0] FEV_UNFROZE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_I,
        ST_MUL_P,
        ST_UPDATE,
        ST_PCT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: src/sampled_pi_deadband_antiwindup.sv
// Sampled PI voltage regulator with deadband and back-calculation anti-windup.
// A tick item that completes a sample period runs one controller step through
// a single shared 32x17 multiplier (integral term, then proportional term,
// then clamp and integrator correction); a tick that only counts, freezes or
// sits inside the deadband skips the multiplier and goes straight to ST_DONE.
// An init item divides stator_sum * 16384 by qr_sum in the bit-serial divider,
// one quotient bit per cycle over 46 bits; with qr_sum zero the divider is
// skipped and the level takes the limit by sign. One item is in work at a time;
// a finished result waits in the output register while the next item is taken.
// Depends on spda_pkg, spda_div and the assertion macro header.
`default_nettype none
`include "sampled_pi_deadband_antiwindup_macros.svh"

module sampled_pi_deadband_antiwindup
    import spda_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] voltage, [23:16] blocker_mask, [55:24] stator_sum
    input  wire logic [55:0] s_axis_tdata,
    // [0] op
    input  wire logic [0:0]  s_axis_tuser,
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] level, [16] activated, [17] level_step, [19:18] freeze_event, [23:20] zero
    output logic [23:0]      m_axis_tdata
);

    // configuration
    logic [15:0]        r_ref_voltage, n_ref_voltage;
    logic [15:0]        r_deadband, n_deadband;
    logic [31:0]        r_gain_i, n_gain_i;
    logic [31:0]        r_gain_p, n_gain_p;
    logic [15:0]        r_sample_period, n_sample_period;
    logic [3:0]         r_active_gen, n_active_gen;
    logic [30:0]        r_qr_sum, n_qr_sum;

    // controller state
    t_state             r_state, n_state;
    logic signed [31:0] r_integrator, n_integrator;
    logic signed [15:0] r_level, n_level;
    logic [15:0]        r_period_count, n_period_count;
    logic               r_frozen, n_frozen;
    logic               r_out_valid, n_out_valid;

    // per-item working registers
    logic signed [16:0] r_err, n_err;
    logic signed [48:0] r_prod, n_prod;
    logic signed [31:0] r_itmp, n_itmp;
    logic signed [15:0] r_old_level, n_old_level;
    logic               r_neg, n_neg;
    logic               r_activated, n_activated;
    logic               r_step, n_step;
    logic [1:0]         r_fev, n_fev;
    logic [23:0]        r_out_data, n_out_data;

    // input fields
    logic               w_in_op;
    logic [15:0]        w_in_volt;
    logic [MASK_W-1:0]  w_in_mask;
    logic [31:0]        w_in_stator;
    logic               w_accept;

    logic signed [16:0] w_err;
    logic signed [17:0] w_band_lo;
    logic               w_outside;
    logic [5:0]         w_n_gen;
    logic               w_blocked;
    logic               w_due;

    logic [31:0]        w_mag;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;
    logic signed [15:0] w_div_level;

    logic [31:0]        w_mul_gain;
    logic signed [48:0] w_mul;
    logic signed [49:0] w_prod_rnd;
    logic signed [33:0] w_term;
    logic signed [34:0] w_isum;
    logic signed [34:0] w_raw;
    logic signed [15:0] w_lv;
    logic signed [35:0] w_corr;

    function automatic logic signed [31:0] f_sat32(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sd2147483647;
        lo = -36'sd2147483648;
        if (v > hi) begin
            return 32'sh7FFFFFFF;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

    function automatic logic signed [15:0] f_clamp(input logic signed [34:0] v);
        if (v > 35'(LVL_HI)) begin
            return LVL_HI;
        end else if (v < 35'(LVL_LO)) begin
            return LVL_LO;
        end
        return 16'(v);
    endfunction

    // level * 100 / 16384, truncated toward zero
    function automatic logic signed [8:0] f_pct(input logic signed [15:0] lv);
        logic signed [23:0] x;
        x = 24'(lv) * 24'(PCT_SCALE);
        if (x < 0) begin
            x = x + 24'sd16383;
        end
        return 9'(x >>> FRAC_W);
    endfunction

    assign w_in_op     = s_axis_tuser[0];
    assign w_in_volt   = s_axis_tdata[15:0];
    assign w_in_mask   = s_axis_tdata[23:16];
    assign w_in_stator = s_axis_tdata[55:24];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // sample decision terms
    assign w_err     = $signed({1'b0, r_ref_voltage}) - $signed({1'b0, w_in_volt});
    assign w_band_lo = $signed({2'b00, r_ref_voltage}) - $signed({2'b00, r_deadband});
    assign w_outside = ($signed({2'b00, w_in_volt}) < w_band_lo)
                    || ({1'b0, w_in_volt} > ({1'b0, r_ref_voltage} + {1'b0, r_deadband}));
    assign w_due     = ({1'b0, r_period_count} + 17'd1) >= {1'b0, r_sample_period};
    assign w_n_gen   = ({2'b00, r_active_gen} > 6'(MAX_GENERATORS))
                     ? 6'(MAX_GENERATORS) : {2'b00, r_active_gen};

    always_comb begin
        w_blocked = 1'b1;
        for (int i = 0; i < MASK_W; i++) begin
            if ((6'(i) < w_n_gen) && !w_in_mask[i]) begin
                w_blocked = 1'b0;
            end
        end
        // generators beyond the mask count as unblocked
        if (w_n_gen > 6'(MASK_W)) begin
            w_blocked = 1'b0;
        end
    end

    // init divide: |stator| * 2^14 / qr_sum
    assign w_mag              = w_in_stator[31] ? (~w_in_stator + 32'd1) : w_in_stator;
    assign w_div_req.start    = w_accept && (w_in_op == OP_INIT) && (r_qr_sum != '0);
    assign w_div_req.dividend = {w_mag, {FRAC_W{1'b0}}};
    assign w_div_req.divisor  = r_qr_sum;

    spda_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        if (r_neg) begin
            if (w_div_rsp.quotient > DIV_NUM_W'(-LEVEL_LOW)) begin
                w_div_level = LVL_LO;
            end else begin
                w_div_level = 16'd0 - w_div_rsp.quotient[15:0];
            end
        end else begin
            if (w_div_rsp.quotient > DIV_NUM_W'(LEVEL_HIGH)) begin
                w_div_level = LVL_HI;
            end else begin
                w_div_level = w_div_rsp.quotient[15:0];
            end
        end
    end

    // shared multiplier: integral gain first, proportional gain next
    assign w_mul_gain = (r_state == ST_MUL_I) ? r_gain_i : r_gain_p;
    assign w_mul      = 49'($signed(w_mul_gain)) * 49'(r_err);

    // round half up into Q.14
    assign w_prod_rnd = 50'(r_prod) + 50'sd32768;
    assign w_term     = w_prod_rnd[49:16];
    assign w_isum     = 35'(r_integrator) + 35'(w_term);
    assign w_raw      = 35'(r_itmp) + 35'(w_term);
    assign w_lv       = f_clamp(w_raw);
    assign w_corr     = 36'(r_itmp) + 36'(w_lv) - 36'(w_raw);

    always_comb begin
        n_ref_voltage   = r_ref_voltage;
        n_deadband      = r_deadband;
        n_gain_i        = r_gain_i;
        n_gain_p        = r_gain_p;
        n_sample_period = r_sample_period;
        n_active_gen    = r_active_gen;
        n_qr_sum        = r_qr_sum;

        n_state         = r_state;
        n_integrator    = r_integrator;
        n_level         = r_level;
        n_period_count  = r_period_count;
        n_frozen        = r_frozen;
        n_out_valid     = r_out_valid && !m_axis_tready;

        n_err           = r_err;
        n_prod          = r_prod;
        n_itmp          = r_itmp;
        n_old_level     = r_old_level;
        n_neg           = r_neg;
        n_activated     = r_activated;
        n_step          = r_step;
        n_fev           = r_fev;
        n_out_data      = r_out_data;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REF:    n_ref_voltage   = i_cfg_data[15:0];
                CFG_DB:     n_deadband      = i_cfg_data[15:0];
                CFG_KI:     n_gain_i        = i_cfg_data;
                CFG_KP:     n_gain_p        = i_cfg_data;
                CFG_PERIOD: n_sample_period = i_cfg_data[15:0];
                CFG_NGEN:   n_active_gen    = i_cfg_data[3:0];
                CFG_QR:     n_qr_sum        = i_cfg_data[30:0];
                default: begin
                end
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_activated = 1'b0;
                    n_step      = 1'b0;
                    n_fev       = FEV_NONE;
                    n_neg       = w_in_stator[31];
                    n_state     = ST_DONE;
                    if (w_in_op == OP_INIT) begin
                        if (r_qr_sum != '0) begin
                            n_state = ST_DIV;
                        end else begin
                            // zero divisor: take the limit by sign
                            if (w_in_stator[31]) begin
                                n_level = LVL_LO;
                            end else if (w_in_stator != '0) begin
                                n_level = LVL_HI;
                            end else begin
                                n_level = '0;
                            end
                            n_integrator = 32'(n_level);
                        end
                    end else if (w_due) begin
                        n_period_count = '0;
                        n_activated    = 1'b1;
                        n_frozen       = w_blocked;
                        if (w_blocked && !r_frozen) begin
                            n_fev = FEV_FROZE;
                        end else if (!w_blocked && r_frozen) begin
                            n_fev = FEV_UNFROZE;
                        end
                        if (!w_blocked && w_outside) begin
                            n_err       = w_err;
                            n_old_level = r_level;
                            n_state     = ST_MUL_I;
                        end
                    end else begin
                        n_period_count = r_period_count + 16'd1;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    n_level      = w_div_level;
                    n_integrator = 32'(w_div_level);
                    n_state      = ST_DONE;
                end
            end
            ST_MUL_I: begin
                n_prod  = w_mul;
                n_state = ST_MUL_P;
            end
            ST_MUL_P: begin
                n_prod  = w_mul;
                n_itmp  = f_sat32(36'(w_isum));
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                // clamp and pull the integrator back by the clamped amount
                n_level      = w_lv;
                n_integrator = f_sat32(w_corr);
                n_state      = ST_PCT;
            end
            ST_PCT: begin
                n_step  = f_pct(r_old_level) != f_pct(r_level);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0000, r_fev, r_step, r_activated, r_level};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_voltage   <= 16'd16384;
            r_deadband      <= '0;
            r_gain_i        <= '0;
            r_gain_p        <= '0;
            r_sample_period <= 16'd10;
            r_active_gen    <= '0;
            r_qr_sum        <= 31'd1;
            r_state         <= ST_IDLE;
            r_integrator    <= '0;
            r_level         <= '0;
            r_period_count  <= '0;
            r_frozen        <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_ref_voltage   <= n_ref_voltage;
            r_deadband      <= n_deadband;
            r_gain_i        <= n_gain_i;
            r_gain_p        <= n_gain_p;
            r_sample_period <= n_sample_period;
            r_active_gen    <= n_active_gen;
            r_qr_sum        <= n_qr_sum;
            r_state         <= n_state;
            r_integrator    <= n_integrator;
            r_level         <= n_level;
            r_period_count  <= n_period_count;
            r_frozen        <= n_frozen;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err       <= n_err;
        r_prod      <= n_prod;
        r_itmp      <= n_itmp;
        r_old_level <= n_old_level;
        r_neg       <= n_neg;
        r_activated <= n_activated;
        r_step      <= n_step;
        r_fev       <= n_fev;
        r_out_data  <= n_out_data;
    end

    `SPDA_ASSERT_ALWAYS(a_level_range, i_clk, i_rst_n, (r_level <= LVL_HI) && (r_level >= LVL_LO))
    `SPDA_ASSERT_NEXT(a_sample_clears_count, i_clk, i_rst_n, w_accept && (w_in_op == OP_TICK) && w_due, r_period_count == '0)
    `SPDA_ASSERT_NEXT(a_frozen_holds_level, i_clk, i_rst_n, w_accept && (w_in_op == OP_TICK) && w_due && w_blocked, $stable(r_level))
    `SPDA_ASSERT_NEXT(a_init_sets_integrator, i_clk, i_rst_n, (r_state == ST_DIV) && w_div_rsp.done, r_integrator == 32'(r_level))

endmodule

`default_nettype wire

// File: src/spda_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on spda_pkg for widths and the request/response types.
`default_nettype none

module spda_div
    import spda_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_DEN_W-1:0] r_rem, n_rem;
    logic [DIV_NUM_W-1:0] r_quo, n_quo;
    logic [DIV_DEN_W-1:0] r_den, n_den;

    logic [DIV_DEN_W:0]   w_trial;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(DIV_NUM_W - 1);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            // shift the dividend out of the top while quotient bits enter below
            n_rem = w_ge ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
            n_quo = {r_quo[DIV_NUM_W-2:0], w_ge};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// File: verif/tb_sampled_pi_deadband_antiwindup.sv
// Self-checking testbench for sampled_pi_deadband_antiwindup: directed and random
// items through the stream ports, checked against a cycle-free controller predictor.
// Depends on spda_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_sampled_pi_deadband_antiwindup
    import spda_pkg::*;
();

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 60;
    localparam logic [2:0]  CFG_UNUSED     = 3'd7;

    typedef struct packed {
        logic signed [15:0] level;
        logic               activated;
        logic               level_step;
        logic [1:0]         freeze_event;
    } t_ctrl_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [15:0] voltage, [23:16] blocker_mask, [55:24] stator_sum
    logic [55:0] s_axis_tdata = '0;
    // [0] op
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] level, [16] activated, [17] level_step, [19:18] freeze_event
    logic [23:0] m_axis_tdata;

    // predictor copy of the registers and the controller state
    logic [15:0]        cfg_ref = 16'd16384;
    logic [15:0]        cfg_db = '0;
    logic signed [31:0] cfg_ki = '0;
    logic signed [31:0] cfg_kp = '0;
    logic [15:0]        cfg_period = 16'd10;
    logic [3:0]         cfg_ngen = '0;
    logic [30:0]        cfg_qr = 31'd1;
    logic signed [31:0] integ = '0;
    logic signed [15:0] level_q = '0;
    logic [15:0]        period_cnt = '0;
    logic               frozen_q = 1'b0;

    t_ctrl_out ctrl_expect[$];
    int        mismatch_count = 0;
    int        stall_cycles = 0;
    int        snd_idle_pct = 35;
    int        rcv_idle_pct = 48;
    int        hold_req = 0;
    int        hold_left = 0;

    sampled_pi_deadband_antiwindup u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_lvl(input longint v);
        if (v > LEVEL_HIGH) return LEVEL_HIGH;
        if (v < LEVEL_LOW) return LEVEL_LOW;
        return v;
    endfunction

    // gain * error is Q.30; round half up back to Q.14
    function automatic longint gain_q14(input logic signed [31:0] g, input longint err);
        return (longint'(g) * err + 64'sd32768) >>> 16;
    endfunction

    function automatic int pct_of(input logic signed [15:0] lv);
        return (int'(lv) * PCT_SCALE) / 16384;
    endfunction

    function automatic t_ctrl_out ctrl_step(input logic op, input logic [15:0] volt,
                                            input logic [7:0] mask,
                                            input logic signed [31:0] stator);
        t_ctrl_out          r;
        longint             q, err, itmp, raw, lv, vref, vdb, vv;
        logic               blocked;
        logic signed [15:0] old_level;
        int                 ngen;
        r = '0;
        if (op == OP_INIT) begin
            if (cfg_qr == 0)
                q = (stator > 0) ? LEVEL_HIGH : ((stator < 0) ? LEVEL_LOW : 0);
            else
                q = (longint'(stator) * 16384) / longint'(cfg_qr);
            level_q = 16'(clamp_lvl(q));
            integ = 32'(level_q);
        end else if (int'(period_cnt) + 1 >= int'(cfg_period)) begin
            period_cnt = '0;
            r.activated = 1'b1;
            ngen = (cfg_ngen > MAX_GENERATORS) ? MAX_GENERATORS : int'(cfg_ngen);
            blocked = 1'b1;
            for (int i = 0; i < ngen; i++) begin
                if (i >= MASK_W || !mask[i]) blocked = 1'b0;
            end
            if (blocked && !frozen_q) r.freeze_event = FEV_FROZE;
            else if (!blocked && frozen_q) r.freeze_event = FEV_UNFROZE;
            frozen_q = blocked;
            if (!frozen_q) begin
                vref = longint'(cfg_ref);
                vdb = longint'(cfg_db);
                vv = longint'(volt);
                if (vv < vref - vdb || vv > vref + vdb) begin
                    err = vref - vv;
                    itmp = sat32(longint'(integ) + gain_q14(cfg_ki, err));
                    raw = itmp + gain_q14(cfg_kp, err);
                    lv = clamp_lvl(raw);
                    old_level = level_q;
                    // back-calculation: pull the integrator by the clamp amount
                    integ = 32'(sat32(itmp + (lv - raw)));
                    level_q = 16'(lv);
                    r.level_step = (pct_of(old_level) != pct_of(level_q));
                end
            end
        end else begin
            period_cnt = period_cnt + 16'd1;
        end
        r.level = level_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_REF:    cfg_ref = data[15:0];
            CFG_DB:     cfg_db = data[15:0];
            CFG_KI:     cfg_ki = data;
            CFG_KP:     cfg_kp = data;
            CFG_PERIOD: cfg_period = data[15:0];
            CFG_NGEN:   cfg_ngen = data[3:0];
            CFG_QR:     cfg_qr = data[30:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_item(input logic op, input logic [15:0] volt, input logic [7:0] mask,
                             input logic [31:0] stator);
        t_ctrl_out predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = op;
        s_axis_tdata = {stator, mask, volt};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = ctrl_step(op, volt, mask, stator);
        ctrl_expect = {ctrl_expect, predicted};
    endtask

    // stop offering and wait for every predicted result
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (ctrl_expect.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        // ten ticks reach the default period; no generators means freeze
        for (int n = 0; n < 10; n++)
            send_item(OP_TICK, 16'($urandom()), 8'($urandom()), $urandom());
        drain();
    endtask

    task automatic test_init_level();
        cfg_write(CFG_QR, 32'd1);
        send_item(OP_INIT, 16'h0000, 8'h00, 32'h7FFF_FFFF);
        send_item(OP_INIT, 16'hFFFF, 8'hFF, 32'h8000_0000);
        drain();
        cfg_write(CFG_QR, 32'd0);
        send_item(OP_INIT, '0, '0, 32'd5);
        send_item(OP_INIT, '0, '0, -32'sd5);
        send_item(OP_INIT, '0, '0, 32'd0);
        drain();
        cfg_write(CFG_QR, 32'hFFFF_FFFF);
        send_item(OP_INIT, '0, '0, -32'sd123456789);
        drain();
    endtask

    task automatic test_control_extremes();
        cfg_write(CFG_PERIOD, 32'd0);
        cfg_write(CFG_NGEN, 32'hF);
        cfg_write(CFG_REF, 32'd16384);
        cfg_write(CFG_DB, 32'd100);
        cfg_write(CFG_KI, 32'h7FFF_FFFF);
        cfg_write(CFG_KP, 32'h8000_0000);
        cfg_write(CFG_UNUSED, 32'hDEAD_BEEF);
        send_item(OP_TICK, 16'd0, 8'hFF, '0);
        send_item(OP_TICK, 16'd0, 8'h7F, '0);
        send_item(OP_TICK, 16'hFFFF, 8'h00, '0);
        send_item(OP_TICK, 16'd16484, 8'h00, '0);
        send_item(OP_TICK, 16'd16283, 8'h00, '0);
        send_item(OP_TICK, 16'd0, 8'h01, '0);
        drain();
    endtask

    task automatic test_period_change();
        cfg_write(CFG_PERIOD, 32'hFFFF);
        repeat (3) send_item(OP_TICK, 16'd0, 8'h00, '0);
        drain();
        // new period below the running count: the next tick samples
        cfg_write(CFG_PERIOD, 32'd1);
        send_item(OP_TICK, 16'd0, 8'h00, '0);
        drain();
    endtask

    task automatic randomize_config();
        int v;
        if ($urandom_range(9) < 6) v = 16384 + int'($urandom_range(8192)) - 4096;
        else v = int'($urandom_range(65535));
        cfg_write(CFG_REF, {16'($urandom()), 16'(v)});
        v = ($urandom_range(9) == 0) ? int'($urandom_range(65535)) : int'($urandom_range(300));
        cfg_write(CFG_DB, {16'($urandom()), 16'(v)});
        v = ($urandom_range(4) == 0) ? int'($urandom()) : int'($urandom_range(262144)) - 131072;
        cfg_write(CFG_KI, 32'(v));
        v = ($urandom_range(4) == 0) ? int'($urandom()) : int'($urandom_range(262144)) - 131072;
        cfg_write(CFG_KP, 32'(v));
        case ($urandom_range(19))
            0:               v = 65535;
            1, 2, 3, 4, 5:   v = int'($urandom_range(12, 4));
            default:         v = int'($urandom_range(3));
        endcase
        cfg_write(CFG_PERIOD, {16'($urandom()), 16'(v)});
        v = ($urandom_range(4) == 0) ? int'($urandom_range(15)) : int'($urandom_range(8, 1));
        cfg_write(CFG_NGEN, {28'($urandom()), 4'(v)});
        v = ($urandom_range(9) == 0) ? 0 : int'($urandom() >> $urandom_range(30, 1));
        cfg_write(CFG_QR, {1'($urandom()), 31'(v)});
    endtask

    task automatic send_random_item();
        int          v, s;
        logic [7:0]  mask;
        case ($urandom_range(3))
            0:       mask = 8'hFF;
            1:       mask = 8'h00;
            default: mask = 8'($urandom());
        endcase
        if ($urandom_range(9) < 7) begin
            v = int'(cfg_ref) + int'($urandom_range(4096)) - 2048;
            v = (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
        end else begin
            v = int'($urandom_range(65535));
        end
        if ($urandom_range(1) == 0) s = int'($urandom());
        else s = int'($urandom_range(2097152)) - 1048576;
        send_item(($urandom_range(9) == 0) ? OP_INIT : OP_TICK, 16'(v), mask, 32'(s));
    endtask

    task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0) begin
                drain();
                randomize_config();
            end
            send_random_item();
        end
        drain();
    endtask

    task automatic test_output_stall();
        // receiver holds off long enough for the block to stall its input
        hold_req = 300;
        repeat (12) send_random_item();
        drain();
    endtask

    // receiver: random ready, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_ctrl_out   want;
        logic [23:0] got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (ctrl_expect.size() == 0) begin
                report_mismatch("result with nothing pending", 0, got);
            end else begin
                want = ctrl_expect.pop_front();
                if (got[15:0] !== want.level)
                    report_mismatch("level", want.level, $signed(got[15:0]));
                if (got[16] !== want.activated)
                    report_mismatch("activated", want.activated, got[16]);
                if (got[17] !== want.level_step)
                    report_mismatch("level_step", want.level_step, got[17]);
                if (got[19:18] !== want.freeze_event)
                    report_mismatch("freeze_event", want.freeze_event, got[19:18]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     stall_cycles, ctrl_expect.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_init_level();
        test_control_extremes();
        test_period_change();
        test_random_traffic(170, 35, 48);
        test_random_traffic(170, 48, 35);
        test_random_traffic(160, 0, 0);
        test_output_stall();

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ctrl_expect.size() != 0)
            report_mismatch("results still pending", 0, ctrl_expect.size());
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
